// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the steering block; they compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define AST_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: property violated");

// expression must never be true outside reset
`define AST_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define AST_PROP(lbl, clk, rstn, prop)
`define AST_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: design/wdps_pkg.sv
// ----------------------------------------------------------------------------
// wdps_pkg
// Widths, register indexes, reset values and the controller command word of
// the wall distance PID steering block.
// ----------------------------------------------------------------------------
package wdps_pkg;

  // field and register widths
  localparam int unsigned DIST_W     = 12;
  localparam int unsigned BASE_W     = 7;
  localparam int unsigned LIM_W      = 10;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CORR_W     = 11;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 3'd5;

  // register reset values
  localparam logic [DIST_W-1:0] TARGET_RST = 12'd240;
  localparam logic [BASE_W-1:0] BASE_RST   = 7'd85;
  localparam logic [LIM_W-1:0]  LIMIT_RST  = 10'd640;
  localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd1572864;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd10;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd10;

  // integrator clamp, 100 cm in 1/16 cm
  localparam logic signed [11:0] INTEG_MAX = 12'sd1600;

  // multiplier operand select
  localparam logic [1:0] MUL_P = 2'd0;
  localparam logic [1:0] MUL_I = 2'd1;
  localparam logic [1:0] MUL_D = 2'd2;

  // controller to datapath command word
  typedef struct packed {
    logic       load;      // capture input word
    logic       err_en;    // error, integrator and difference step
    logic       mul_en;    // run the shared multiplier
    logic [1:0] mul_sel;   // which gain product
    logic       sum_init;  // start the product sum
    logic       sum_add;   // add the last product
    logic       corr_en;   // scale and clamp the correction
    logic       out_load;  // load the result word
  } wdps_cmd_t;

endpackage

// File: design/wdps_ctrl.sv
// ----------------------------------------------------------------------------
// wdps_ctrl
// Sequencer for one control tick: error step, three gain products on the shared
// multiplier, product sum, correction clamp, result load; a restart word goes
// straight to the result load. Owns both handshakes.
`include "assert_macros.svh"

module wdps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_restart,
  output logic                 in_tready,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output wdps_pkg::wdps_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_MP   = 3'd2;
  localparam logic [2:0] S_MI   = 3'd3;
  localparam logic [2:0] S_MD   = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_LIM  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_restart ? S_OUT : S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_en = 1'b1;
        state_nxt  = S_MP;
      end
      S_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wdps_pkg::MUL_P;
        state_nxt   = S_MI;
      end
      S_MI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = wdps_pkg::MUL_I;
        cmd.sum_init = 1'b1;
        state_nxt    = S_MD;
      end
      S_MD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wdps_pkg::MUL_D;
        cmd.sum_add = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.sum_add = 1'b1;
        state_nxt   = S_LIM;
      end
      S_LIM: begin
        cmd.corr_en = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous word is still unread
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `AST_PROP(a_accept_to_err, clk, rst_n, (in_tvalid && in_tready && !in_restart) |=> (state_r == S_ERR))
  `AST_PROP(a_no_overwrite, clk, rst_n, cmd.out_load |-> (!out_valid_r || out_tready))
  `AST_PROP(a_valid_from_out, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_OUT))

endmodule

// File: design/wdps_dp.sv
// ----------------------------------------------------------------------------
// wdps_dp
// Datapath: config registers, per-side integrator and last error, shared
// 25x14 multiplier with product sum, correction clamp, wheel speed mapping
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdps_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wdps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [wdps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic [wdps_pkg::DIST_W-1:0]          in_dist,
  input  logic                                 in_side,
  input  logic                                 in_restart,
  input  wdps_pkg::wdps_cmd_t                  cmd,
  output logic [wdps_pkg::OUT_DATA_W-1:0]      out_word
);

  // configuration
  logic [wdps_pkg::DIST_W-1:0] tgt_r;
  logic [wdps_pkg::BASE_W-1:0] base_r;
  logic [wdps_pkg::LIM_W-1:0]  lim_r;
  logic [wdps_pkg::GAIN_W-1:0] kp_r, ki_r, kd_r;

  // captured input word
  logic [wdps_pkg::DIST_W-1:0] dist_r;
  logic                        side_r;
  logic                        rst_item_r;

  // per-side history, index 0 right wall, 1 left wall
  logic signed [11:0] integ_r [2];
  logic signed [12:0] prev_r  [2];

  // error step
  logic signed [12:0] err;
  logic signed [11:0] integ_sel;
  logic signed [12:0] prev_sel;
  logic signed [13:0] acc_raw;
  logic signed [11:0] acc_cl;
  logic signed [13:0] diff;
  logic signed [12:0] err_r;
  logic signed [11:0] acc_r;
  logic signed [13:0] diff_r;

  // multiply and sum
  logic        [wdps_pkg::GAIN_W-1:0] gain_op;
  logic signed [13:0] mul_b;
  logic signed [38:0] prod_r;
  logic signed [39:0] sum_r;

  // correction
  logic signed [19:0] sum_sh;
  logic signed [19:0] lim_ext;
  logic signed [10:0] lim_s;
  logic signed [10:0] corr_nxt;
  logic signed [10:0] corr_r;

  // speed mapping
  logic signed [12:0] n_plus, n_minus;
  logic signed [15:0] base160, corr16, corr_x11, n_left;
  logic signed [15:0] n_left_abs;
  logic        [9:0]  q_pre;
  logic        [17:0] q_mul;
  logic        [7:0]  q160;
  logic signed [8:0]  div160;
  logic signed [8:0]  spd_plus, spd_minus;
  logic        [7:0]  left_nxt, right_nxt;
  logic        [7:0]  left_r, right_r;
  logic        [10:0] corr_out_r;

  // truncate toward zero, divide by 16
  function automatic logic signed [8:0] trunc16(input logic signed [12:0] x);
    logic signed [12:0] adj;
    adj = x[12] ? (x + 13'sd15) : x;
    return $signed(adj[12:4]);
  endfunction

  // cap from above only
  function automatic logic [7:0] cap95(input logic signed [8:0] s);
    return (s > 9'sd95) ? 8'd95 : s[7:0];
  endfunction

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= wdps_pkg::TARGET_RST;
      base_r <= wdps_pkg::BASE_RST;
      lim_r  <= wdps_pkg::LIMIT_RST;
      kp_r   <= wdps_pkg::GAIN_P_RST;
      ki_r   <= wdps_pkg::GAIN_I_RST;
      kd_r   <= wdps_pkg::GAIN_D_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        wdps_pkg::REG_TARGET: tgt_r  <= cfg_wdata[wdps_pkg::DIST_W-1:0];
        wdps_pkg::REG_BASE:   base_r <= cfg_wdata[wdps_pkg::BASE_W-1:0];
        wdps_pkg::REG_LIMIT:  lim_r  <= cfg_wdata[wdps_pkg::LIM_W-1:0];
        wdps_pkg::REG_GAIN_P: kp_r   <= cfg_wdata[wdps_pkg::GAIN_W-1:0];
        wdps_pkg::REG_GAIN_I: ki_r   <= cfg_wdata[wdps_pkg::GAIN_W-1:0];
        wdps_pkg::REG_GAIN_D: kd_r   <= cfg_wdata[wdps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dist_r     <= in_dist;
      side_r     <= in_side;
      rst_item_r <= in_restart;
    end
  end

  // error, clamped integrator, difference
  always_comb begin
    integ_sel = integ_r[side_r];
    prev_sel  = prev_r[side_r];
    err       = $signed({1'b0, dist_r}) - $signed({1'b0, tgt_r});
    acc_raw   = $signed({{2{integ_sel[11]}}, integ_sel}) + $signed({err[12], err});
    if (acc_raw > 14'sd1600) begin
      acc_cl = wdps_pkg::INTEG_MAX;
    end else if (acc_raw < -14'sd1600) begin
      acc_cl = -wdps_pkg::INTEG_MAX;
    end else begin
      acc_cl = acc_raw[11:0];
    end
    diff = $signed({err[12], err}) - $signed({prev_sel[12], prev_sel});
  end

  // history registers; restart clears both sides
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r[0] <= '0;
      integ_r[1] <= '0;
      prev_r[0]  <= '0;
      prev_r[1]  <= '0;
    end else if (cmd.load && in_restart) begin
      integ_r[0] <= '0;
      integ_r[1] <= '0;
      prev_r[0]  <= '0;
      prev_r[1]  <= '0;
    end else if (cmd.err_en) begin
      integ_r[side_r] <= acc_cl;
      prev_r[side_r]  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_en) begin
      err_r  <= err;
      acc_r  <= acc_cl;
      diff_r <= diff;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      wdps_pkg::MUL_P: begin
        gain_op = kp_r;
        mul_b   = $signed({err_r[12], err_r});
      end
      wdps_pkg::MUL_I: begin
        gain_op = ki_r;
        mul_b   = $signed({{2{acc_r[11]}}, acc_r});
      end
      default: begin
        gain_op = kd_r;
        mul_b   = diff_r;
      end
    endcase
  end

  // product register and running sum
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= $signed({1'b0, gain_op}) * mul_b;
    end
    if (cmd.sum_init) begin
      sum_r <= $signed({prod_r[38], prod_r});
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + $signed({prod_r[38], prod_r});
    end
  end

  // floor by 2^20, then clamp to the limit
  always_comb begin
    sum_sh  = sum_r[39:20];
    lim_ext = $signed({10'b0, lim_r});
    lim_s   = $signed({1'b0, lim_r});
    if (sum_sh > lim_ext) begin
      corr_nxt = lim_s;
    end else if (sum_sh < -lim_ext) begin
      corr_nxt = -lim_s;
    end else begin
      corr_nxt = sum_sh[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.corr_en) begin
      corr_r <= corr_nxt;
    end
  end

  // wheel speeds
  always_comb begin
    n_plus  = $signed({2'b0, base_r, 4'b0}) + $signed({{2{corr_r[10]}}, corr_r});
    n_minus = $signed({2'b0, base_r, 4'b0}) - $signed({{2{corr_r[10]}}, corr_r});
    // 160*base - 11*corr, divided by 160 toward zero: /32 then /5 by reciprocal
    base160    = $signed({2'b0, base_r, 7'b0}) + $signed({4'b0, base_r, 5'b0});
    corr16     = $signed({{5{corr_r[10]}}, corr_r});
    corr_x11   = (corr16 <<< 3) + (corr16 <<< 1) + corr16;
    n_left     = base160 - corr_x11;
    n_left_abs = n_left[15] ? -n_left : n_left;
    q_pre      = n_left_abs[14:5];
    q_mul      = {8'b0, q_pre} * 18'd205;
    q160       = q_mul[17:10];
    div160     = n_left[15] ? -$signed({1'b0, q160}) : $signed({1'b0, q160});
    spd_plus   = trunc16(n_plus);
    spd_minus  = trunc16(n_minus);
    if (rst_item_r) begin
      left_nxt  = '0;
      right_nxt = '0;
    end else if (side_r) begin
      right_nxt = cap95(spd_plus);
      left_nxt  = cap95(div160);
    end else begin
      left_nxt  = cap95(spd_plus);
      right_nxt = cap95(spd_minus);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_r     <= left_nxt;
      right_r    <= right_nxt;
      corr_out_r <= rst_item_r ? 11'd0 : corr_r;
    end
  end

  assign out_word = {5'b0, corr_out_r, right_r, left_r};

  `AST_PROP(a_integ_range, clk, rst_n, (integ_r[0] <= wdps_pkg::INTEG_MAX) && (integ_r[0] >= -wdps_pkg::INTEG_MAX) && (integ_r[1] <= wdps_pkg::INTEG_MAX) && (integ_r[1] >= -wdps_pkg::INTEG_MAX))
  `AST_NEVER(a_corr_range, clk, rst_n, $past(cmd.corr_en) && ((corr_r > lim_s) || (corr_r < -lim_s)))

endmodule

// File: design/wall_distance_pid_steering.sv
// ----------------------------------------------------------------------------
// wall_distance_pid_steering
// Wall-following PID steering: one sonar distance in, two wheel speeds and
// the clamped correction out, with per-side integrator and last error.
// ----------------------------------------------------------------------------
//
//   channel  dir  word contents (lowest bits first)
//   in_*     in   tdata: wall_distance[11:0]; tuser: follow_left, restart
//   out_*    out  tdata: left_speed[7:0], right_speed[15:8], correction_out[26:16]
//   cfg_*    in   write only: index 0..5, data 24 bits
//
// A normal word runs from accept through one error step, three gain products
// in turn on the single 25x14 multiplier, sum, clamp and result load before
// the next word is taken. A restart word goes straight to the result load.
// Reset (rst_n low, synchronous) loads the register defaults and zeroes
// both histories. The next word is taken while a result waits; a stalled
// output holds the sequencer in its load step.
// ----------------------------------------------------------------------------
module wall_distance_pid_steering (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write port
  input  logic                                 cfg_wr_en,
  input  logic [wdps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [wdps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input word
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wdps_pkg::IN_DATA_W-1:0]       in_tdata,  // wall_distance[11:0]
  input  logic [wdps_pkg::IN_USER_W-1:0]       in_tuser,  // follow_left[0], restart[1]
  // result word
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wdps_pkg::OUT_DATA_W-1:0]      out_tdata  // left[7:0] right[15:8] corr[26:16]
);

  wdps_pkg::wdps_cmd_t cmd;

  wdps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tuser[1]),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  wdps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_dist    (in_tdata[wdps_pkg::DIST_W-1:0]),
    .in_side    (in_tuser[0]),
    .in_restart (in_tuser[1]),
    .cmd        (cmd),
    .out_word   (out_tdata)
  );

endmodule
